>>> design/tcp_pkg.sv
// shared constants and codes for the tlv command parser
// no dependencies; used by every module of the block
package tcp_pkg;

  localparam int MAX_PACKET_DEF = 16384;
  localparam int QUEUE_DEPTH    = 4;

  localparam int BYTE_W   = 8;
  localparam int PLEN_W   = 15;
  localparam int TYPE_W   = 8;
  localparam int LEN_W    = 32;
  localparam int VAL_W    = 64;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 64;
  localparam int IN_DW    = 24;
  localparam int OUT_DW   = 176;

  localparam logic REC_OPTION = 1'b0;
  localparam logic REC_END    = 1'b1;

  localparam logic [STAT_W-1:0] ST_MARKER  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANOUT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADLEN  = 2'd2;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd3;

  localparam logic [BYTE_W-1:0] LONG_LEN_FLAG = 8'h80;
  localparam logic [BYTE_W-1:0] LONG_LEN_MASK = 8'h7f;

endpackage

>>> design/tcp_front.sv
// front end: takes the input word apart and normalises the packet length
// depends on tcp_pkg; feeds the queue in front of tcp_back
module tcp_front #(
  parameter int MAX_PACKET = tcp_pkg::MAX_PACKET_DEF,
  parameter int PLW        = $clog2(MAX_PACKET)
) (
  input  logic [tcp_pkg::IN_DW-1:0]      in_word,
  input  logic                           in_first,
  output logic [tcp_pkg::BYTE_W+PLW:0]   item
);
  import tcp_pkg::*;

  logic [BYTE_W-1:0] data_byte;
  logic [PLEN_W-1:0] pkt_len;
  logic [16:0]       len_sat;
  logic [PLW-1:0]    plen_m1;

  assign data_byte = in_word[BYTE_W-1:0];
  assign pkt_len   = in_word[BYTE_W+PLEN_W-1:BYTE_W];

  // zero length counts as one byte, oversize saturates
  always_comb begin
    len_sat = 17'(pkt_len);
    if (len_sat == 17'd0) begin
      len_sat = 17'd1;
    end
    if (len_sat > 17'(MAX_PACKET)) begin
      len_sat = 17'(MAX_PACKET);
    end
    plen_m1 = PLW'(len_sat - 17'd1);
  end

  assign item = {in_first, plen_m1, data_byte};

endmodule

>>> design/tcp_queue.sv
// short word queue between the front end and the parser back end
// depends on tcp_pkg for its default depth
module tcp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tcp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> design/tcp_back.sv
// back end: option parser state machine and the output record register
// depends on tcp_pkg; takes words from tcp_queue
module tcp_back #(
  parameter int MAX_PACKET = tcp_pkg::MAX_PACKET_DEF,
  parameter int PLW        = $clog2(MAX_PACKET)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tcp_pkg::TYPE_W-1:0]    end_marker,
  input  logic                          q_valid,
  input  logic [tcp_pkg::BYTE_W+PLW:0]  q_item,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [tcp_pkg::OUT_DW-1:0]    out_tdata,
  output logic                          out_tuser
);
  import tcp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_TYPE, PH_LEN, PH_LENEXT, PH_VALUE, PH_DONE
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [PLW-1:0]     pos_r, pos_nxt;
  logic [PLW-1:0]     plen_r, plen_nxt;
  logic [TYPE_W-1:0]  type_r, type_nxt;
  logic [6:0]         lbl_r, lbl_nxt;
  logic [LEN_W-1:0]   clen_r, clen_nxt;
  logic [LEN_W-1:0]   vbl_r, vbl_nxt;
  logic [VAL_W-1:0]   acc_r, acc_nxt;
  logic [STAT_W-1:0]  stop_r, stop_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               o_kind_r;
  logic [TYPE_W-1:0]  o_type_r;
  logic [LEN_W-1:0]   o_len_r;
  logic [VAL_W-1:0]   o_val_r;
  logic [STAT_W-1:0]  o_stat_r;
  logic [COUNT_W-1:0] o_cnt_r;

  logic [BYTE_W-1:0]  q_byte;
  logic [PLW-1:0]     q_plen;
  logic               q_first;

  logic               emit, fin, hd, active;
  logic [LEN_W-1:0]   hlen;
  logic [PLW-1:0]     pos_c;
  logic [LEN_W:0]     hd_sum;
  logic [STAT_W-1:0]  fin_stat;

  assign q_byte  = q_item[BYTE_W-1:0];
  assign q_plen  = q_item[BYTE_W+PLW-1:BYTE_W];
  assign q_first = q_item[BYTE_W+PLW];

  assign q_pop = q_valid && (!out_valid_r || out_tready);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    plen_nxt  = plen_r;
    type_nxt  = type_r;
    lbl_nxt   = lbl_r;
    clen_nxt  = clen_r;
    vbl_nxt   = vbl_r;
    acc_nxt   = acc_r;
    stop_nxt  = stop_r;
    cnt_nxt   = cnt_r;
    emit      = 1'b0;
    fin       = 1'b0;
    hd        = 1'b0;
    hlen      = '0;
    pos_c     = pos_r;
    hd_sum    = '0;
    fin_stat  = ST_BADLEN;
    active    = 1'b0;
    if (q_pop) begin
      if (q_first) begin
        active   = 1'b1;
        plen_nxt = q_plen;
        pos_nxt  = '0;
        pos_c    = '0;
        if (q_byte == '0) begin
          stop_nxt  = ST_IGNORED;
          phase_nxt = PH_DONE;
        end else begin
          cnt_nxt   = cnt_r + COUNT_W'(1);
          phase_nxt = PH_TYPE;
        end
      end else if (phase_r != PH_IDLE) begin
        active  = 1'b1;
        pos_c   = pos_r + PLW'(1);
        pos_nxt = pos_c;
        case (phase_r)
          PH_TYPE: begin
            if (q_byte == end_marker) begin
              stop_nxt  = ST_MARKER;
              phase_nxt = PH_DONE;
            end else begin
              type_nxt  = q_byte;
              phase_nxt = PH_LEN;
            end
          end
          PH_LEN: begin
            if ((q_byte & LONG_LEN_FLAG) != '0) begin
              lbl_nxt  = 7'(q_byte & LONG_LEN_MASK);
              clen_nxt = '0;
              if (lbl_nxt == '0) begin
                hd = 1'b1;
              end else begin
                phase_nxt = PH_LENEXT;
              end
            end else begin
              clen_nxt = LEN_W'(q_byte);
              hd       = 1'b1;
            end
          end
          PH_LENEXT: begin
            clen_nxt = {clen_r[LEN_W-BYTE_W-1:0], q_byte};
            lbl_nxt  = lbl_r - 7'd1;
            if (lbl_nxt == '0) begin
              hd = 1'b1;
            end
          end
          PH_VALUE: begin
            acc_nxt = {acc_r[VAL_W-BYTE_W-1:0], q_byte};
            vbl_nxt = vbl_r - LEN_W'(1);
            if (vbl_nxt == '0) begin
              phase_nxt = PH_TYPE;
              emit      = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      // option header complete: check that the value ends before the payload end
      if (hd) begin
        hlen   = clen_nxt;
        hd_sum = (LEN_W+1)'(pos_c) + (LEN_W+1)'(hlen);
        if (hd_sum >= (LEN_W+1)'(plen_nxt)) begin
          stop_nxt  = ST_BADLEN;
          phase_nxt = PH_DONE;
        end else if (hlen == '0) begin
          acc_nxt   = '0;
          phase_nxt = PH_TYPE;
          emit      = 1'b1;
        end else begin
          vbl_nxt   = hlen;
          acc_nxt   = '0;
          phase_nxt = PH_VALUE;
        end
      end
      if (active && (pos_c >= plen_nxt)) begin
        fin = 1'b1;
        if (phase_nxt == PH_DONE) begin
          fin_stat = stop_nxt;
        end else if (phase_nxt == PH_TYPE) begin
          fin_stat = ST_RANOUT;
        end else begin
          fin_stat = ST_BADLEN;
        end
        phase_nxt = PH_IDLE;
      end
    end
    if (q_pop && (fin || emit)) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pos_r       <= '0;
      plen_r      <= '0;
      type_r      <= '0;
      lbl_r       <= '0;
      clen_r      <= '0;
      vbl_r       <= '0;
      acc_r       <= '0;
      stop_r      <= ST_MARKER;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      o_kind_r    <= REC_OPTION;
      o_type_r    <= '0;
      o_len_r     <= '0;
      o_val_r     <= '0;
      o_stat_r    <= ST_MARKER;
      o_cnt_r     <= '0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      plen_r      <= plen_nxt;
      type_r      <= type_nxt;
      lbl_r       <= lbl_nxt;
      clen_r      <= clen_nxt;
      vbl_r       <= vbl_nxt;
      acc_r       <= acc_nxt;
      stop_r      <= stop_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (q_pop && fin) begin
        o_kind_r <= REC_END;
        o_type_r <= '0;
        o_len_r  <= '0;
        o_val_r  <= '0;
        o_stat_r <= fin_stat;
        o_cnt_r  <= cnt_nxt;
      end else if (q_pop && emit) begin
        o_kind_r <= REC_OPTION;
        o_type_r <= type_nxt;
        o_len_r  <= clen_nxt;
        o_val_r  <= acc_nxt;
        o_stat_r <= ST_MARKER;
        o_cnt_r  <= cnt_nxt;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_kind_r;
  assign out_tdata  = {6'd0, o_cnt_r, o_stat_r, o_val_r, o_len_r, o_type_r};

endmodule

>>> design/tlv_command_parser.sv
// top level of the tlv command parser: end marker register, front end, queue, back end
// depends on tcp_pkg, tcp_front, tcp_queue and tcp_back
//
// usage:
//   in_*  : one packet byte per word; in_tuser marks the first byte of a packet,
//           whose word also carries the packet length in bytes
//   out_* : one record per word; out_tuser is 0 for an option record,
//           1 for the end record that the last byte of a packet yields
//   cfg_* : writes the end marker type code; cfg_ready is always high,
//           write only while no packet is in flight
// throughput: one byte per cycle sustained; the parser back end pops the queue
//   head whenever the output register is empty or being read, so a record taken
//   straight from the output register never holds it up
// path: an accepted byte is written to a queue slot; the queue head is parsed and
//   the record that it completes is registered in the output register
// stall: while out_tready is low the output register holds its record and
//   up to four bytes gather in the queue before in_tready falls
// reset: command count cleared, parser idle, end marker code 0, queue empty;
//   bytes arriving outside a packet are dropped without a record
module tlv_command_parser #(
  parameter int MAX_PACKET = tcp_pkg::MAX_PACKET_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [tcp_pkg::IN_DW-1:0]    in_tdata,   // data_byte[7:0], packet_length[22:8]
  input  logic                         in_tuser,   // first_byte
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [tcp_pkg::OUT_DW-1:0]   out_tdata,  // option_type[7:0], option_length[39:8],
                                                   // option_value[103:40], end_status[105:104],
                                                   // command_count[169:106]
  output logic                         out_tuser,  // record_kind
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tcp_pkg::TYPE_W-1:0]   cfg_data    // end_marker_code
);
  import tcp_pkg::*;

  localparam int PLW = $clog2(MAX_PACKET);
  localparam int QW  = BYTE_W + PLW + 1;

  logic [TYPE_W-1:0] end_marker_r;
  logic [QW-1:0]     front_item;
  logic [QW-1:0]     q_item;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_marker_r <= '0;
    end else if (cfg_valid) begin
      end_marker_r <= cfg_data;
    end
  end

  assign in_tready = !q_full;

  tcp_front #(
    .MAX_PACKET (MAX_PACKET),
    .PLW        (PLW)
  ) u_front (
    .in_word  (in_tdata),
    .in_first (in_tuser),
    .item     (front_item)
  );

  tcp_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid && !q_full),
    .push_data (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_item)
  );

  tcp_back #(
    .MAX_PACKET (MAX_PACKET),
    .PLW        (PLW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .end_marker (end_marker_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> tb/sv/tlv_check_pkg.sv
`timescale 1ns / 100ps
// record scoreboard for the tlv command parser bench: predicts the records that
// each accepted byte causes and checks the block's records against them; uses tcp_pkg
package tlv_check_pkg;
  import tcp_pkg::*;

  localparam int REC_BITS = TYPE_W + LEN_W + VAL_W + STAT_W + COUNT_W;

  typedef enum logic [2:0] {
    AWAIT_FIRST, AWAIT_TYPE, AWAIT_LEN, AWAIT_LEN_EXT, IN_VALUE, SKIP_TO_END
  } parse_phase_t;

  typedef struct {
    logic               kind;
    logic [TYPE_W-1:0]  opt_type;
    logic [LEN_W-1:0]   opt_len;
    logic [VAL_W-1:0]   opt_value;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] cmd_count;
  } tlv_record_t;

  class record_scoreboard;
    tlv_record_t        pending_records[$];
    int                 mismatches;
    logic [TYPE_W-1:0]  end_marker;

    logic [COUNT_W-1:0] commands_seen;
    parse_phase_t       phase;
    int unsigned        byte_pos;
    int unsigned        payload_len;
    logic [TYPE_W-1:0]  cur_type;
    logic [6:0]         len_bytes_left;
    logic [LEN_W-1:0]   cur_len;
    logic [LEN_W-1:0]   value_left;
    logic [VAL_W-1:0]   value_acc;
    logic [STAT_W-1:0]  stop_status;

    function new();
      mismatches     = 0;
      end_marker     = '0;
      commands_seen  = '0;
      phase          = AWAIT_FIRST;
      byte_pos       = 0;
      payload_len    = 0;
      cur_type       = '0;
      len_bytes_left = '0;
      cur_len        = '0;
      value_left     = '0;
      value_acc      = '0;
      stop_status    = ST_MARKER;
    endfunction

    function void set_marker(logic [TYPE_W-1:0] code);
      end_marker = code;
    endfunction

    function int pending();
      return pending_records.size();
    endfunction

    function void push_record(logic kind, logic [TYPE_W-1:0] t, logic [LEN_W-1:0] l,
                              logic [VAL_W-1:0] v, logic [STAT_W-1:0] st);
      tlv_record_t rec;
      rec.kind      = kind;
      rec.opt_type  = t;
      rec.opt_len   = l;
      rec.opt_value = v;
      rec.status    = st;
      rec.cmd_count = commands_seen;
      pending_records.push_back(rec);
    endfunction

    // header complete: reject if the value would reach the payload end
    function bit finish_header(int unsigned pos);
      if (64'(pos) + 64'(cur_len) >= 64'(payload_len)) begin
        stop_status = ST_BADLEN;
        phase       = SKIP_TO_END;
        return 1'b0;
      end
      value_acc = '0;
      if (cur_len == 0) begin
        phase = AWAIT_TYPE;
        return 1'b1;
      end
      value_left = cur_len;
      phase      = IN_VALUE;
      return 1'b0;
    endfunction

    function void predict_byte(logic [BYTE_W-1:0] b, logic [PLEN_W-1:0] plen, logic first);
      int unsigned       len;
      int unsigned       pos;
      bit                emit;
      logic [STAT_W-1:0] st;
      emit = 1'b0;
      if (first) begin
        len = plen;
        if (len == 0) len = 1;
        if (len > MAX_PACKET_DEF) len = MAX_PACKET_DEF;
        payload_len = len - 1;
        byte_pos    = 0;
        pos         = 0;
        if (b == 0) begin
          stop_status = ST_IGNORED;
          phase       = SKIP_TO_END;
        end else begin
          commands_seen++;
          phase = AWAIT_TYPE;
        end
      end else begin
        if (phase == AWAIT_FIRST) return;
        byte_pos++;
        pos = byte_pos;
        case (phase)
          AWAIT_TYPE: begin
            if (b == end_marker) begin
              stop_status = ST_MARKER;
              phase       = SKIP_TO_END;
            end else begin
              cur_type = b;
              phase    = AWAIT_LEN;
            end
          end
          AWAIT_LEN: begin
            if ((b & LONG_LEN_FLAG) != 0) begin
              len_bytes_left = 7'(b & LONG_LEN_MASK);
              cur_len        = '0;
              if (len_bytes_left == 0) emit = finish_header(pos);
              else phase = AWAIT_LEN_EXT;
            end else begin
              cur_len = LEN_W'(b);
              emit    = finish_header(pos);
            end
          end
          AWAIT_LEN_EXT: begin
            cur_len        = {cur_len[LEN_W-9:0], b};
            len_bytes_left = len_bytes_left - 7'd1;
            if (len_bytes_left == 0) emit = finish_header(pos);
          end
          IN_VALUE: begin
            value_acc  = {value_acc[VAL_W-9:0], b};
            value_left = value_left - 1;
            if (value_left == 0) begin
              phase = AWAIT_TYPE;
              emit  = 1'b1;
            end
          end
          default: ;
        endcase
      end

      if (pos >= payload_len) begin
        if (phase == SKIP_TO_END) st = stop_status;
        else if (phase == AWAIT_TYPE) st = ST_RANOUT;
        else st = ST_BADLEN;
        phase = AWAIT_FIRST;
        push_record(REC_END, '0, '0, '0, st);
      end else if (emit) begin
        push_record(REC_OPTION, cur_type, cur_len, value_acc, '0);
      end
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_record(logic kind, logic [OUT_DW-1:0] data);
      tlv_record_t want;
      if (pending_records.size() == 0) begin
        $error("unexpected record: kind %0b data %h", kind, data);
        mismatches++;
        return;
      end
      want = pending_records.pop_front();
      compare_field("record_kind", 64'(want.kind), 64'(kind));
      compare_field("option_type", 64'(want.opt_type), 64'(data[7:0]));
      compare_field("option_length", 64'(want.opt_len), 64'(data[39:8]));
      compare_field("option_value", want.opt_value, data[103:40]);
      compare_field("end_status", 64'(want.status), 64'(data[105:104]));
      compare_field("command_count", want.cmd_count, data[169:106]);
      compare_field("tdata_pad", 64'd0, 64'(data[OUT_DW-1:REC_BITS]));
    endfunction
  endclass

endpackage

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// top of the tlv command parser bench: clock, reset, byte and record drivers, watchdog
// depends on tcp_pkg, tlv_check_pkg and the tlv_command_parser block
module tb;
  import tcp_pkg::*;
  import tlv_check_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 120;
  localparam int PHASES       = 8;
  localparam int PHASE_BYTES  = 115;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata   = '0;
  logic                in_tuser   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_DW-1:0]   out_tdata;
  logic                out_tuser;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [TYPE_W-1:0]   cfg_data   = '0;

  record_scoreboard    sb;
  logic [BYTE_W-1:0]   frame[$];
  logic [TYPE_W-1:0]   marker_now = '0;
  int                  bytes_sent = 0;
  int                  burst_left = 0;
  bit                  steady     = 1'b0;
  bit                  rx_free    = 1'b1;
  bit                  hold_req   = 1'b0;
  logic [15:0]         rx_pattern = 16'hffff;
  int                  rx_left    = 0;
  int                  quiet_cycles = 0;

  tlv_command_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // record side: own stall pattern, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_pattern = 16'($urandom) | 16'h0101;
          rx_left    = 64;
        end
        rx_left--;
        rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
        out_tready <= rx_free ? 1'b1 : rx_pattern[0];
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_record(out_tuser, out_tdata);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic [PLEN_W-1:0] plen,
                           input logic first);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, plen, b};
    in_tuser  <= first;
    do @(posedge clk); while (!in_tready);
    sb.predict_byte(b, plen, first);
  endtask

  function automatic int full_count(input logic [PLEN_W-1:0] plen);
    if (plen == 0) return 1;
    if (plen > MAX_PACKET_DEF) return MAX_PACKET_DEF;
    return plen;
  endfunction

  // first word carries the length; filler beyond the frame is random
  task automatic send_frame(input logic [PLEN_W-1:0] plen, input int count);
    for (int i = 0; i < count; i++) begin
      send_byte(i < frame.size() ? frame[i] : 8'($urandom),
                i == 0 ? plen : PLEN_W'($urandom), i == 0);
    end
    bytes_sent += count;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_marker(input logic [TYPE_W-1:0] code);
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    do @(posedge clk); while (!cfg_ready);
    sb.set_marker(code);
    marker_now = code;
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_option();
    int len;
    int n;
    int form;
    frame.push_back(8'($urandom));
    len  = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
    form = $urandom_range(0, 9);
    if (form < 6) begin
      frame.push_back(8'(len));
    end else if (form == 6) begin
      len = 0;
      frame.push_back(LONG_LEN_FLAG);
    end else begin
      // form 9 sends more than four length bytes, the top ones junk
      n = (form == 9) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      frame.push_back(LONG_LEN_FLAG | 8'(n));
      for (int k = n - 1; k >= 0; k--) begin
        frame.push_back(k >= 4 ? 8'($urandom) : 8'(len >> (8 * k)));
      end
    end
    repeat (len) frame.push_back(8'($urandom));
  endfunction

  function automatic void build_command();
    frame = {};
    frame.push_back(($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
    repeat ($urandom_range(0, 4)) add_option();
    case ($urandom_range(0, 7))
      0, 1, 2: begin
        frame.push_back(marker_now);
        repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom));
      end
      3: begin
        // long length that mostly overruns the packet
        frame.push_back(8'($urandom));
        frame.push_back(LONG_LEN_FLAG | 8'd2);
        frame.push_back(8'($urandom));
        frame.push_back(8'($urandom));
      end
      4: frame.push_back(8'($urandom));
      5: begin
        frame.push_back(8'($urandom));
        frame.push_back(LONG_LEN_FLAG | 8'd3);
        frame.push_back(8'($urandom));
      end
      default: ;
    endcase
  endfunction

  task automatic random_packet();
    int n;
    logic [PLEN_W-1:0] plen;
    build_command();
    n = frame.size();
    case ($urandom_range(0, 7))
      0: plen = PLEN_W'($urandom_range(1, n));
      1: plen = PLEN_W'(n + $urandom_range(1, 6));
      default: plen = PLEN_W'(n);
    endcase
    send_frame(plen, full_count(plen));
  endtask

  initial begin
    int target;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: end marker still at its reset value of zero
    frame = {8'h00};
    send_frame(15'd1, 1);
    frame = {8'hff};
    send_frame(15'd0, 1);
    send_byte(8'h5a, 15'h7fff, 1'b0);
    frame = {8'h01, 8'h11, 8'h02, 8'haa, 8'hbb, 8'h22, 8'h81, 8'h03, 8'h01, 8'h02, 8'h03,
             8'h33, 8'h00, 8'h44, 8'h80, 8'h00, 8'h55};
    send_frame(15'd17, 17);
    frame = {8'h02, 8'h66, 8'h85, 8'hff, 8'h00, 8'h00, 8'h00, 8'h01, 8'h9c, 8'h77};
    send_frame(15'd10, 10);
    frame = {8'h03, 8'h12, 8'h05, 8'h01, 8'h02, 8'h03};
    send_frame(15'd6, 6);
    frame = {8'h04, 8'h13, 8'h82, 8'h00};
    send_frame(15'd4, 4);
    // restart abandons this packet without an end record
    frame = {8'h05, 8'h14, 8'h01};
    send_frame(15'd50, 3);
    frame = {8'h06, 8'h5a, 8'h0a, 8'hf0, 8'he1, 8'hd2, 8'hc3, 8'hb4, 8'ha5, 8'h96, 8'h87,
             8'h78, 8'h69, 8'h00, 8'hff};
    send_frame(15'd15, 15);
    // oversized length saturates to the largest packet, so this long option
    // reaches the capped payload end; a restart then cuts the packet short
    frame = {8'h07, 8'h21, 8'h83, 8'h00, 8'h3f, 8'hfb};
    send_frame(15'h7fff, 6);
    frame = {8'h08};
    send_frame(15'd1, 1);

    bytes_sent = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: write_marker(8'hff);
        2: write_marker(8'h80);
        3: write_marker(8'h00);
        5: write_marker(8'h01);
        7: write_marker(8'h7f);
        default: write_marker(8'($urandom));
      endcase
      steady  = (ph == 2 || ph == 5);
      rx_free = (ph == 2 || ph == 6);
      if (ph == 3) hold_req = 1'b1;
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        case ($urandom_range(0, 19))
          0: begin
            // stray words outside any packet, dropped by the block
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), PLEN_W'($urandom), 1'b0);
          end
          1, 2: begin
            build_command();
            send_frame(PLEN_W'($urandom), $urandom_range(1, 6));
          end
          default: ;
        endcase
        random_packet();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
design/tcp_pkg.sv
design/tcp_front.sv
design/tcp_queue.sv
design/tcp_back.sv
design/tlv_command_parser.sv
tb/sv/tlv_check_pkg.sv
tb/sv/tb.sv
